FILE: rtl/utf8_decode_and_count_top_assert.svh
// Assertion macros for the UTF-8 decoder and character counter.
// Included by the top level; needs nothing else.
`ifndef UTF8_DECODE_AND_COUNT_TOP_ASSERT_SVH
`define UTF8_DECODE_AND_COUNT_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define UDC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define UDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/utf8dc_pkg.sv
// Package for the UTF-8 decoder and character counter.
// Holds the byte ranges, field widths and the decode plan struct; no dependencies.
package utf8dc_pkg;

    localparam int CP_W       = 21;
    localparam int SHOWN_W    = 32;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 56;
    localparam int M_USER_W   = 2;
    localparam int RES_CNT_W  = 3;
    localparam int RES_IDX_W  = 2;

    localparam logic [7:0] ASCII_HI  = 8'h7F;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF7;

    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    typedef struct packed {
        logic [RES_CNT_W-1:0] n_err;
        logic                 has_data;
        logic [CP_W-1:0]      data_cp;
        logic [1:0]           next_need;
        logic [1:0]           next_taken;
        logic [CP_W-1:0]      next_part;
    } t_plan;

endpackage

FILE: rtl/utf8_decode_and_count_top.sv
// Top level of the streaming UTF-8 decoder with a running character count.
// Uses utf8dc_pkg and the assertion macros in utf8_decode_and_count_top_assert.svh.
// Each byte is held in the input register and each result in the output register.
// Throughput: one byte per cycle unless stalled; a byte with N results (up to four)
// holds the input register, as the single output register takes one result per cycle.
// Reset: synchronous, active low; clears both registers' valid flags, the open sequence
// and the count.
module utf8_decode_and_count_top
    import utf8dc_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    // Bits 7:0 data_byte.
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_s_tlast,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    // Bits 20:0 code_point, 52:21 char_total, 53 run_last, 55:54 zero.
    output logic [M_DATA_W-1:0] o_m_tdata,
    // Bit 0 is_error, bit 1 counted.
    output logic [M_USER_W-1:0] o_m_tuser,
    output logic                o_m_tlast
);

    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    logic [1:0]             r_need;
    logic [1:0]             r_taken;
    logic [CP_W-1:0]        r_part;
    logic [COUNT_WIDTH-1:0] r_count;
    logic [RES_IDX_W-1:0]   r_idx;
    logic                   r_out_valid;
    logic [CP_W-1:0]        r_out_cp;
    logic                   r_out_err;
    logic                   r_out_cnt;
    logic [SHOWN_W-1:0]     r_out_shown;
    logic                   r_out_run_last;
    logic                   r_out_done;

    t_plan                  w_plan;
    logic [RES_CNT_W-1:0]   w_total;
    logic [1:0]             w_taken1;
    logic [CP_W-1:0]        w_val;
    logic                   w_res_err;
    logic [CP_W-1:0]        w_res_cp;
    logic                   w_res_cnt;
    logic                   w_res_last;
    logic [COUNT_WIDTH-1:0] n_count;
    logic [63:0]            w_count_ext;
    logic [SHOWN_W-1:0]     w_shown;
    logic                   w_out_free;
    logic                   w_emit;
    logic                   w_retire;

    assign w_taken1 = r_taken + 2'd1;
    assign w_val    = {r_part[CP_W-7:0], r_in_byte[5:0]};

    always_comb begin
        w_plan.n_err      = '0;
        w_plan.has_data   = 1'b0;
        w_plan.data_cp    = '0;
        w_plan.next_need  = r_need;
        w_plan.next_taken = r_taken;
        w_plan.next_part  = r_part;
        if (r_need != NEED_NONE && r_in_byte inside {[CONT_LO:CONT_HI]}) begin
            w_plan.next_part  = w_val;
            w_plan.next_taken = w_taken1;
            if (w_taken1 >= r_need) begin
                w_plan.has_data   = 1'b1;
                w_plan.data_cp    = w_val;
                w_plan.next_need  = NEED_NONE;
                w_plan.next_taken = 2'd0;
                w_plan.next_part  = '0;
            end else if (r_in_last) begin
                w_plan.n_err      = RES_CNT_W'(w_taken1) + RES_CNT_W'(1);
                w_plan.next_need  = NEED_NONE;
                w_plan.next_taken = 2'd0;
                w_plan.next_part  = '0;
            end
        end else begin
            if (r_need != NEED_NONE) begin
                w_plan.n_err = RES_CNT_W'(r_taken) + RES_CNT_W'(1);
            end
            w_plan.next_need  = NEED_NONE;
            w_plan.next_taken = 2'd0;
            w_plan.next_part  = '0;
            if (r_in_byte <= ASCII_HI) begin
                w_plan.has_data = 1'b1;
                w_plan.data_cp  = CP_W'(r_in_byte);
            end else if (r_in_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
                w_plan.next_need = NEED_ONE;
                w_plan.next_part = CP_W'(r_in_byte[4:0]);
            end else if (r_in_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
                w_plan.next_need = NEED_TWO;
                w_plan.next_part = CP_W'(r_in_byte[3:0]);
            end else if (r_in_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
                w_plan.next_need = NEED_THREE;
                w_plan.next_part = CP_W'(r_in_byte[2:0]);
            end else begin
                w_plan.n_err = w_plan.n_err + RES_CNT_W'(1);
            end
            if (r_in_last && w_plan.next_need != NEED_NONE) begin
                w_plan.n_err      = w_plan.n_err + RES_CNT_W'(1);
                w_plan.next_need  = NEED_NONE;
                w_plan.next_part  = '0;
            end
        end
    end

    assign w_total    = w_plan.n_err + RES_CNT_W'(w_plan.has_data);
    assign w_res_err  = RES_CNT_W'(r_idx) < w_plan.n_err;
    assign w_res_cp   = w_res_err ? '0 : w_plan.data_cp;
    assign w_res_cnt  = w_res_err || !(w_plan.data_cp == '0 && r_in_last);
    assign w_res_last = RES_CNT_W'(r_idx) == (w_total - RES_CNT_W'(1));

    assign n_count     = (w_res_cnt && r_count != '1) ? r_count + COUNT_WIDTH'(1) : r_count;
    assign w_count_ext = 64'(n_count);
    assign w_shown     = (|w_count_ext[63:SHOWN_W]) ? '1 : w_count_ext[SHOWN_W-1:0];

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_emit     = r_in_valid && w_total != '0 && w_out_free;
    assign w_retire   = r_in_valid && (w_total == '0 || (w_emit && w_res_last));
    assign o_s_tready = !r_in_valid || w_retire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_need      <= NEED_NONE;
            r_taken     <= 2'd0;
            r_part      <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= w_emit;
            end
            if (w_emit) begin
                r_idx <= w_res_last ? '0 : r_idx + RES_IDX_W'(1);
            end
            if (w_retire && r_in_last) begin
                r_count <= '0;
            end else if (w_emit) begin
                r_count <= n_count;
            end
            if (w_retire) begin
                r_need  <= w_plan.next_need;
                r_taken <= w_plan.next_taken;
                r_part  <= w_plan.next_part;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
        if (w_emit) begin
            r_out_cp       <= w_res_cp;
            r_out_err      <= w_res_err;
            r_out_cnt      <= w_res_cnt;
            r_out_shown    <= w_shown;
            r_out_run_last <= w_res_last;
            r_out_done     <= w_res_last && r_in_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_run_last, r_out_shown, r_out_cp};
    assign o_m_tuser  = {r_out_cnt, r_out_err};
    assign o_m_tlast  = r_out_done;

`include "utf8_decode_and_count_top_assert.svh"

    `UDC_ASSERT_SAME(a_idx_needs_item, i_clk, i_rst_n, r_idx != '0, r_in_valid,
        "Result index advanced with no byte held.")
    `UDC_ASSERT_SAME(a_error_zero_cp, i_clk, i_rst_n, r_out_valid && r_out_err,
        r_out_cp == '0 && r_out_cnt, "Error result carries a code point or is uncounted.")
    `UDC_ASSERT_SAME(a_done_is_run_last, i_clk, i_rst_n, r_out_valid && r_out_done,
        r_out_run_last, "Final result of a text is not the last result of its byte.")
    `UDC_ASSERT_NEXT(a_text_end_clears, i_clk, i_rst_n, w_retire && r_in_last,
        r_need == NEED_NONE && r_count == '0, "State not cleared after text end.")

endmodule
